// File: rtl/bse_pkg.sv
package bse_pkg;

  localparam int VALUE_BITS = 16;

  typedef struct packed {
    logic load;
    logic width;
    logic count_step;
    logic rewind;
    logic gather_step;
    logic emit_step;
    logic advance;
    logic clear;
  } bse_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic bucket_end;
    logic last_bucket;
  } bse_sts_t;

endpackage

// File: rtl/bse_ctrl.sv
module bse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              in_last_i,
  input  logic              out_free_i,
  input  bse_pkg::bse_sts_t sts_i,
  output bse_pkg::bse_cmd_t cmd_o,
  output logic              in_ready_o
);
  import bse_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_WIDTH, S_COUNT, S_GATHER, S_EMIT, S_CLEAR
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      case (state_q)
        S_LOAD: if (in_fire_i && in_last_i) state_q <= S_WIDTH;
        S_WIDTH: state_q <= S_COUNT;
        S_COUNT: if (sts_i.scan_done) state_q <= S_GATHER;
        S_GATHER: if (sts_i.scan_done) state_q <= S_EMIT;
        S_EMIT: if (sts_i.bucket_end) state_q <= sts_i.last_bucket ? S_CLEAR : S_GATHER;
        S_CLEAR: state_q <= S_LOAD;
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_fire_i;
    cmd_o.width = (state_q == S_WIDTH);
    cmd_o.count_step = (state_q == S_COUNT) && !sts_i.scan_done;
    cmd_o.rewind = (state_q == S_COUNT) && sts_i.scan_done;
    cmd_o.gather_step = (state_q == S_GATHER) && !sts_i.scan_done;
    cmd_o.emit_step = (state_q == S_EMIT) && !sts_i.bucket_end && out_free_i;
    cmd_o.advance = (state_q == S_EMIT) && sts_i.bucket_end && !sts_i.last_bucket;
    cmd_o.clear = (state_q == S_CLEAR);
  end

endmodule

// File: rtl/bse_datapath.sv
module bse_datapath #(
  parameter int NUM_BUCKETS = 6,
  parameter int BUCKET_CAPACITY = 10,
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bse_pkg::bse_cmd_t cmd_i,
  input  logic [15:0]       in_value_i,
  output bse_pkg::bse_sts_t sts_o,
  output logic [15:0]       out_value_o,
  output logic              out_last_o,
  output logic [7:0]        out_dropped_o
);
  import bse_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int FW = $clog2(BUCKET_CAPACITY + 1);
  localparam int SW = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int QW = VALUE_BITS + 1;
  localparam int MW = QW + 1;
  localparam int PW = QW + MW;
  localparam int SH = QW + $clog2(NUM_BUCKETS);
  localparam int RECIP = ((1 << SH) + NUM_BUCKETS - 1) / NUM_BUCKETS;
  localparam int TW = QW + BW;
  localparam int TOTAL = NUM_BUCKETS * BUCKET_CAPACITY;
  localparam int NW = $clog2(TOTAL + 1);

  logic [VALUE_BITS-1:0] store_q [MAX_ITEMS];
  logic [CW-1:0] count_q;
  logic [VALUE_BITS-1:0] max_q;
  logic [7:0] drop_q;
  logic [QW-1:0] width_q;
  logic [CW-1:0] rd_idx_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic rd_vld_q;
  logic [FW-1:0] fill_q [NUM_BUCKETS];
  logic [BW-1:0] cur_b_q;
  logic [VALUE_BITS-1:0] slot_q [BUCKET_CAPACITY];
  logic [FW-1:0] slot_n_q;
  logic [FW-1:0] emit_k_q;
  logic [NW-1:0] emit_n_q;

  logic [VALUE_BITS-1:0] vin;
  logic store_full;
  logic rd_issue;
  logic [QW-1:0] dividend;
  logic [PW-1:0] product;
  logic [BW-1:0] rd_bkt;
  logic [BUCKET_CAPACITY-1:0] ins_at;
  logic do_insert;
  logic drop_inc;
  logic [NW-1:0] total;

  assign vin = in_value_i[VALUE_BITS-1:0];
  assign store_full = (count_q == CW'(MAX_ITEMS));
  assign rd_issue = (cmd_i.count_step || cmd_i.gather_step) && (rd_idx_q != count_q);

  // The bucket width is ceil(max / N) + 1, with the division done by a
  // reciprocal multiplication that is exact over the whole dividend range.
  assign dividend = QW'(max_q) + QW'(NUM_BUCKETS - 1);
  assign product = dividend * MW'(RECIP);

  always_comb begin
    rd_bkt = '0;
    for (int k = 1; k < NUM_BUCKETS; k++) begin
      if (TW'(rd_val_q) >= TW'(width_q) * TW'(k)) rd_bkt = rd_bkt + 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < BUCKET_CAPACITY; j++) begin
      ins_at[j] = (FW'(j) >= slot_n_q) || (slot_q[j] > rd_val_q);
    end
  end

  assign do_insert = cmd_i.gather_step && rd_vld_q && (rd_bkt == cur_b_q) &&
                     (slot_n_q != FW'(BUCKET_CAPACITY));

  assign drop_inc = (cmd_i.load && store_full) ||
                    (cmd_i.count_step && rd_vld_q &&
                     fill_q[rd_bkt] == FW'(BUCKET_CAPACITY));

  always_comb begin
    total = '0;
    for (int b = 0; b < NUM_BUCKETS; b++) total = total + NW'(fill_q[b]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !store_full) store_q[count_q[AW-1:0]] <= vin;
    if (rd_issue) rd_val_q <= store_q[rd_idx_q[AW-1:0]];
  end

  // Values of the current bucket are kept in ascending order as they arrive.
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      if (ins_at[0]) slot_q[0] <= rd_val_q;
      for (int j = 1; j < BUCKET_CAPACITY; j++) begin
        if (ins_at[j]) slot_q[j] <= ins_at[j-1] ? slot_q[j-1] : rd_val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q <= '0;
      drop_q <= '0;
      width_q <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      cur_b_q <= '0;
      slot_n_q <= '0;
      emit_k_q <= '0;
      emit_n_q <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) fill_q[b] <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      max_q <= '0;
      drop_q <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) fill_q[b] <= '0;
    end else begin
      if (cmd_i.load && !store_full) begin
        count_q <= count_q + 1'b1;
        if (vin > max_q) max_q <= vin;
      end
      if (drop_inc && drop_q != 8'hFF) drop_q <= drop_q + 1'b1;
      if (cmd_i.count_step && rd_vld_q && fill_q[rd_bkt] != FW'(BUCKET_CAPACITY)) begin
        fill_q[rd_bkt] <= fill_q[rd_bkt] + 1'b1;
      end
      if (cmd_i.width || cmd_i.rewind || cmd_i.advance) begin
        rd_idx_q <= '0;
        rd_vld_q <= 1'b0;
        slot_n_q <= '0;
        emit_k_q <= '0;
      end else begin
        if (cmd_i.count_step || cmd_i.gather_step) begin
          rd_vld_q <= rd_issue;
          if (rd_issue) rd_idx_q <= rd_idx_q + 1'b1;
        end
        if (do_insert) slot_n_q <= slot_n_q + 1'b1;
        if (cmd_i.emit_step) emit_k_q <= emit_k_q + 1'b1;
      end
      if (cmd_i.width) begin
        width_q <= QW'(product >> SH) + 1'b1;
        cur_b_q <= '0;
        emit_n_q <= '0;
      end else begin
        if (cmd_i.advance) cur_b_q <= cur_b_q + 1'b1;
        if (cmd_i.emit_step) emit_n_q <= emit_n_q + 1'b1;
      end
    end
  end

  assign sts_o.scan_done = (rd_idx_q == count_q) && !rd_vld_q;
  assign sts_o.bucket_end = (emit_k_q == slot_n_q);
  assign sts_o.last_bucket = (cur_b_q == BW'(NUM_BUCKETS - 1));

  assign out_value_o = slot_q[emit_k_q[SW-1:0]];
  assign out_last_o = (emit_n_q + 1'b1 == total);
  assign out_dropped_o = drop_q;
endmodule

// File: rtl/bucket_sort_engine_top.sv
// Loading accepts one value per cycle until the value marked last.
// Sorting then computes the bucket width, scans the stored values once to size the
// buckets and, for each bucket, scans them again to gather and order its values,
// then emits its results as the sink takes them and moves on to the next bucket.
// After the last bucket a clear step resets the run state and loading resumes.
// Asynchronous active-low reset returns the block to loading with empty state.
module bucket_sort_engine_top #(
  parameter int NUM_BUCKETS = 6,
  parameter int BUCKET_CAPACITY = 10,
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // sorted_value, dropped
  output logic        m_axis_tlast
);
  import bse_pkg::*;

  bse_cmd_t cmd;
  bse_sts_t sts;
  logic in_fire;
  logic free;
  logic [15:0] val;
  logic lst;
  logic [7:0] drp;
  logic [15:0] ov_q;
  logic [7:0] od_q;
  logic ol_q, ovld_q;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign free = !ovld_q || m_axis_tready;

  bse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_last_i(s_axis_tlast),
    .out_free_i(free), .sts_i(sts), .cmd_o(cmd),
    .in_ready_o(s_axis_tready)
  );

  bse_datapath #(
    .NUM_BUCKETS(NUM_BUCKETS), .BUCKET_CAPACITY(BUCKET_CAPACITY),
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_value_i(s_axis_tdata), .sts_o(sts),
    .out_value_o(val), .out_last_o(lst), .out_dropped_o(drp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovld_q <= 1'b0;
    else if (cmd.emit_step) ovld_q <= 1'b1;
    else if (m_axis_tready) ovld_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd.emit_step) begin
      ov_q <= val;
      ol_q <= lst;
      od_q <= drp;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {od_q, ov_q};
  assign m_axis_tlast = ol_q;
endmodule

// File: rtl/bse_checker.sv
module bse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while waiting");
  a_lastin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result after last");
  a_inlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("request taken during sort");
endmodule

bind bucket_sort_engine_top bse_checker u_chk (.*);

// File: sim/bucket_sort_engine_top_test.sv
`timescale 1ns / 1ps

module bucket_sort_engine_top_test;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [15:0] sorted_value;
    logic        last_res;
    logic [7:0]  dropped;
  } sorted_t;

  localparam int NBKT = 6;
  localparam int CAP = 10;
  localparam int DEPTH = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  bucket_sort_engine_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  sample_t     pending_q[$];
  sorted_t     sorted_q[$];
  logic [15:0] run_vals[$];
  logic [15:0] run_max;
  logic [7:0]  run_drops;
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;
  bit          send_pause;

  // Predicts the results of one run when its last value is accepted.
  task automatic predict_run();
    logic [15:0] bkt[NBKT][CAP];
    int          fill[NBKT];
    int          width;
    int          rounded;
    int          idx;
    int          total;
    int          n;
    logic [15:0] tmp;
    sorted_t     r;
    foreach (fill[b]) fill[b] = 0;
    rounded = run_max;
    if (rounded % NBKT != 0) rounded += NBKT - rounded % NBKT;
    width = rounded / NBKT + 1;
    foreach (run_vals[i]) begin
      idx = run_vals[i] / width;
      if (idx >= NBKT) idx = NBKT - 1;
      if (fill[idx] < CAP) begin
        bkt[idx][fill[idx]] = run_vals[i];
        fill[idx]++;
      end else if (run_drops != 8'hff) begin
        run_drops++;
      end
    end
    total = 0;
    for (int b = 0; b < NBKT; b++) begin
      for (int i = 1; i < fill[b]; i++) begin
        for (int j = i; j > 0 && bkt[b][j-1] > bkt[b][j]; j--) begin
          tmp = bkt[b][j];
          bkt[b][j] = bkt[b][j-1];
          bkt[b][j-1] = tmp;
        end
      end
      total += fill[b];
    end
    n = 0;
    for (int b = 0; b < NBKT; b++) begin
      for (int k = 0; k < fill[b]; k++) begin
        n++;
        r.sorted_value = bkt[b][k];
        r.last_res = (n == total);
        r.dropped = run_drops;
        sorted_q.push_back(r);
      end
    end
    run_vals.delete();
    run_max = '0;
    run_drops = '0;
  endtask

  task automatic accept_sample(input sample_t s);
    if (run_vals.size() < DEPTH) begin
      run_vals.push_back(s.value);
      if (s.value > run_max) run_max = s.value;
    end else if (run_drops != 8'hff) begin
      run_drops++;
    end
    if (s.last) predict_run();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) accept_sample({s_axis_tdata, s_axis_tlast});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && !send_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          {s_axis_tdata, s_axis_tlast} <= pending_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    sorted_t got;
    sorted_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tlast, m_axis_tdata[23:16]};
      if (sorted_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        if (got.sorted_value !== want.sorted_value) begin
          $error("sorted_value expected %0d actual %0d", want.sorted_value, got.sorted_value);
          errors++;
        end
        if (got.last_res !== want.last_res) begin
          $error("last_res expected %0d actual %0d", want.last_res, got.last_res);
          errors++;
        end
        if (got.dropped !== want.dropped) begin
          $error("dropped expected %0d actual %0d", want.dropped, got.dropped);
          errors++;
        end
      end
    end
  end

  task automatic add_run(input int len, input int maxv);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      s.value = $urandom_range(maxv);
      s.last = (i == len - 1);
      pending_q.push_back(s);
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  initial begin
    sample_t s;
    int      len;
    int      sel;
    errors = 0;
    run_max = '0;
    run_drops = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b0;
    send_pause = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    s = '{16'h0000, 1'b1};
    pending_q.push_back(s);
    s = '{16'hffff, 1'b1};
    pending_q.push_back(s);
    pending_q.push_back(sample_t'{16'hffff, 1'b0});
    pending_q.push_back(sample_t'{16'h0000, 1'b0});
    pending_q.push_back(sample_t'{16'h5555, 1'b0});
    pending_q.push_back(sample_t'{16'haaaa, 1'b0});
    pending_q.push_back(sample_t'{16'h0007, 1'b1});
    for (int i = 0; i < 12; i++) pending_q.push_back(sample_t'{16'd3, i == 11});

    send_idle_pct = 15;
    recv_idle_pct = 76;
    for (int r = 0; r < 6; r++) add_run($urandom_range(1, 12), 65535);
    drain();
    send_pause = 1'b1;
    while (sorted_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    send_pause = 1'b0;

    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 70; i++) pending_q.push_back(sample_t'{16'($urandom), i == 69});
    send_idle_pct = 76;
    recv_idle_pct = 15;
    for (int r = 0; r < 5; r++) add_run($urandom_range(1, 15), 65535);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int r = 0; r < 8; r++) begin
      sel = $urandom_range(2);
      len = $urandom_range(1, 14);
      add_run(len, sel == 0 ? 255 : sel == 1 ? 65535 : 12);
    end
    drain();
    while (sorted_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("bucket_sort_engine_top_test OK");
    end else begin
      $display("bucket_sort_engine_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("bucket_sort_engine_top_test NOT OK");
    $finish;
  end

endmodule
